### src/tekd_pkg.sv
// types and constants shared by the escape key decoder modules
`timescale 1ns / 1ps

package tekd_pkg;

    // byte codes recognized by the parser
    localparam logic [7:0] ESC_BYTE  = 8'd27;
    localparam logic [7:0] CHAR_H    = 8'h48;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_TILDE = 8'h7e;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;

    // event kinds
    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_DOWN = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    // button numbers
    localparam logic [7:0] BTN_SEARCH  = 8'd0;
    localparam logic [7:0] BTN_HISTORY = 8'd1;
    localparam logic [7:0] BTN_RANDOM  = 8'd2;

    // number of results caused by one item
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic       last;
    } result_t;

    // results caused by one input item, handed from parser to output buffer
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } batch_t;

endpackage

### src/tekd_parser.sv
// escape sequence parser: phase and prefix state plus result decode
`timescale 1ns / 1ps

module tekd_parser
    import tekd_pkg::*;
#(
    parameter int PREFIX_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,       // consume rx_byte this cycle
    input  logic [7:0] rx_byte,
    output batch_t     batch
);

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_ESCAPE = 3'b010,
        PH_PARAM  = 3'b100
    } phase_t;

    localparam int WIDE_BITS = PREFIX_BITS + 4;

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [PREFIX_BITS-1:0]   prefix_reg;
    logic [PREFIX_BITS-1:0]   prefix_next;
    logic [WIDE_BITS-1:0]     prefix_wide;
    logic [WIDE_BITS-1:0]     prefix_acc;
    logic [3:0]               digit;
    logic                     is_digit;
    logic [7:0]               btn;
    logic                     btn_hit;

    // digit accumulate: prefix * 10 + digit, saturated
    assign is_digit    = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    assign digit       = 4'(rx_byte - CHAR_0);
    assign prefix_wide = WIDE_BITS'(prefix_reg);
    assign prefix_acc  = (prefix_wide << 3) + (prefix_wide << 1) + WIDE_BITS'(digit);

    // terminator match
    always_comb
    begin
        btn     = BTN_SEARCH;
        btn_hit = 1'b0;
        if (rx_byte == CHAR_H)
        begin
            btn     = BTN_SEARCH;
            btn_hit = 1'b1;
        end
        else if (rx_byte == CHAR_F)
        begin
            btn     = BTN_HISTORY;
            btn_hit = 1'b1;
        end
        else if ((rx_byte == CHAR_TILDE) && (prefix_reg == PREFIX_BITS'(5)))
        begin
            btn     = BTN_RANDOM;
            btn_hit = 1'b1;
        end
    end

    // next state and results
    always_comb
    begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        batch.count = CNT_NONE;
        batch.res0  = '{kind: KIND_KEY, code: rx_byte, last: 1'b1};
        batch.res1  = '{kind: KIND_UP, code: btn, last: 1'b1};
        case (phase_reg)
            PH_NORMAL:
            begin
                if (rx_byte == ESC_BYTE)
                begin
                    phase_next  = PH_ESCAPE;
                    prefix_next = '0;
                end
                else
                begin
                    batch.count = CNT_ONE;
                end
            end
            PH_ESCAPE:
            begin
                phase_next = PH_PARAM;
            end
            PH_PARAM:
            begin
                if (is_digit)
                begin
                    if (prefix_acc[WIDE_BITS-1:PREFIX_BITS] != '0)
                        prefix_next = '1;
                    else
                        prefix_next = prefix_acc[PREFIX_BITS-1:0];
                end
                else
                begin
                    phase_next = PH_NORMAL;
                    if (btn_hit)
                    begin
                        batch.count = CNT_TWO;
                        batch.res0  = '{kind: KIND_DOWN, code: btn, last: 1'b0};
                    end
                end
            end
            default:
            begin
                phase_next = PH_NORMAL;
            end
        endcase
        if (!step)
            batch.count = CNT_NONE;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_NORMAL;
            prefix_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
        end
    end

    // a button pair only closes a parameter sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && batch.count == CNT_TWO) |-> (phase_reg == PH_PARAM))
        else $error("button pair outside parameter phase");

    // a key event only comes from the normal phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && batch.count == CNT_ONE) |-> (phase_reg == PH_NORMAL))
        else $error("key event outside normal phase");

    // escape always leads into parameter collection
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_ESCAPE) |=> (phase_reg == PH_PARAM))
        else $error("escape phase did not move to parameter phase");

endmodule

### src/tekd_out_buf.sv
// two-entry result register feeding the master stream
`timescale 1ns / 1ps

module tekd_out_buf
    import tekd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,      // take a new batch this cycle
    input  batch_t  batch,
    output logic    free,      // a batch can be loaded this cycle
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t head
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic       pop;

    assign m_tvalid = (cnt_reg != CNT_NONE);
    assign pop      = m_tvalid && m_tready;
    assign free     = (cnt_reg == CNT_NONE) || ((cnt_reg == CNT_ONE) && m_tready);
    assign head     = slot0_reg;

    // load replaces a drained buffer, pop shifts the second slot forward
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = batch.count;
            slot0_next = batch.res0;
            slot1_next = batch.res1;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    // count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= CNT_NONE;
        else
            cnt_reg <= cnt_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // count never exceeds two
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result count out of range");

    // a pair in flight has last only on its second item
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CNT_TWO) |-> (!slot0_reg.last && slot1_reg.last))
        else $error("last flag misplaced in result pair");

    // loading only into a buffer that is empty or drains this cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("batch loaded over pending results");

endmodule

### src/terminal_escape_key_decoder_top.sv
// top level of the terminal escape key decoder
// path: an accepted byte waits in the input register, is parsed, and its results go into
//   the result register that drives m_tvalid; input stalls while that register is full
// throughput: one byte per cycle while m_tready is high; a button press gives two
//   items that leave in turn through the single output port; input waits for the second
// reset: rst_n clears the parse phase to normal, the prefix to zero and all valid flags
`timescale 1ns / 1ps

module terminal_escape_key_decoder_top
    import tekd_pkg::*;
#(
    parameter int PREFIX_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] event_code
    output logic [1:0] m_tuser,    // [1:0] event_kind
    output logic       m_tlast     // last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       free;
    batch_t     batch;
    result_t    head;

    assign advance  = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    // parse stage
    tekd_parser #(
        .PREFIX_BITS (PREFIX_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .batch   (batch)
    );

    // result register
    tekd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .batch    (batch),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = head.code;
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // a held input item keeps its byte until it is parsed
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input item lost or changed");

endmodule

### verif/terminal_escape_key_decoder_top_test.sv
// self-checking testbench for the terminal escape key decoder
`timescale 1ns / 1ps

module terminal_escape_key_decoder_top_test;
    import tekd_pkg::*;

    localparam int PREFIX_BITS = 16;
    localparam int STIM_BYTES  = 600;

    // parse phases of the decoder, as the predictor tracks them
    typedef enum logic [1:0]
    {
        PH_NORMAL = 2'd0,
        PH_ESCAPE = 2'd1,
        PH_PARAM  = 2'd2
    } parse_phase_t;

    // predicts the key events of each accepted byte and checks the results against them
    class key_event_tracker;
        parse_phase_t            phase;
        logic [PREFIX_BITS-1:0]  prefix;
        result_t                 pending_events[$];
        int                      errors;
        int                      n_bytes;
        int                      n_keys;
        int                      n_presses;
        int                      n_saturated;

        function new();
            phase = PH_NORMAL;
            prefix = '0;
            errors = 0;
            n_bytes = 0;
            n_keys = 0;
            n_presses = 0;
            n_saturated = 0;
        endfunction

        function void push_event(logic [1:0] kind, logic [7:0] code, logic last);
            result_t r;
            r.kind = kind;
            r.code = code;
            r.last = last;
            pending_events.push_back(r);
        endfunction

        // advance the parser by one byte and queue the events it causes
        function void accept_byte(logic [7:0] b);
            longint unsigned grown;
            longint unsigned sat_max;
            logic [7:0]      btn;
            sat_max = (64'd1 << PREFIX_BITS) - 1;
            n_bytes++;
            case (phase)
                PH_NORMAL:
                begin
                    if (b == ESC_BYTE)
                    begin
                        phase = PH_ESCAPE;
                        prefix = '0;
                    end
                    else
                    begin
                        push_event(KIND_KEY, b, 1'b1);
                        n_keys++;
                    end
                end
                PH_ESCAPE:
                begin
                    // the introducer byte is skipped whatever it is
                    phase = PH_PARAM;
                end
                PH_PARAM:
                begin
                    if (b >= CHAR_0 && b <= CHAR_9)
                    begin
                        grown = longint'(prefix) * 10 + longint'(b - CHAR_0);
                        if (grown > sat_max)
                        begin
                            prefix = sat_max[PREFIX_BITS-1:0];
                            n_saturated++;
                        end
                        else
                        begin
                            prefix = grown[PREFIX_BITS-1:0];
                        end
                    end
                    else
                    begin
                        phase = PH_NORMAL;
                        btn = 8'hff;
                        if (b == CHAR_H)
                            btn = BTN_SEARCH;
                        else if (b == CHAR_F)
                            btn = BTN_HISTORY;
                        else if (b == CHAR_TILDE && prefix == 5)
                            btn = BTN_RANDOM;
                        // any other terminator closes the sequence silently
                        if (btn != 8'hff)
                        begin
                            push_event(KIND_DOWN, btn, 1'b0);
                            push_event(KIND_UP, btn, 1'b1);
                            n_presses++;
                        end
                    end
                end
                default:
                begin
                    phase = PH_NORMAL;
                end
            endcase
        endfunction

        // compare one result item with the oldest queued event
        function void check_event(logic [1:0] kind, logic [7:0] code, logic last);
            result_t exp_ev;
            if (pending_events.size() == 0)
            begin
                $error("result with nothing pending: kind %0d code 0x%02h last %0d",
                       kind, code, last);
                errors++;
                return;
            end
            exp_ev = pending_events.pop_front();
            if (kind !== exp_ev.kind)
            begin
                $error("event_kind: expected %0d, got %0d", exp_ev.kind, kind);
                errors++;
            end
            if (code !== exp_ev.code)
            begin
                $error("event_code: expected 0x%02h, got 0x%02h", exp_ev.code, code);
                errors++;
            end
            if (last !== exp_ev.last)
            begin
                $error("last_of_run: expected %0d, got %0d", exp_ev.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    key_event_tracker tracker = new();
    bit               burst_mode;
    int               bytes_sent;

    terminal_escape_key_decoder_top #(
        .PREFIX_BITS (PREFIX_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // gap before the next item, none while in a burst stretch
    function automatic int draw_gap();
        if (burst_mode)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    // watch both handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.accept_byte(s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_event(m_tuser, m_tdata, m_tlast);
        end
    end

    // offer one byte and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    // one escape sequence with random introducer, digits and terminator
    task automatic send_sequence();
        int         ndig;
        int         sel;
        logic [7:0] intro;
        logic [7:0] term;
        send_byte(ESC_BYTE);
        case ($urandom_range(0, 3))
            0, 1:    intro = "[";
            2:       intro = "O";
            default: intro = 8'($urandom_range(0, 255));
        endcase
        send_byte(intro);
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            // prefix of five, sometimes with leading zeros
            ndig = $urandom_range(0, 2);
            repeat (ndig) send_byte(CHAR_0);
            send_byte(CHAR_0 + 8'd5);
        end
        else
        begin
            // random digits; an occasional long run can drive the prefix into saturation
            ndig = (sel == 3) ? $urandom_range(5, 8) : $urandom_range(0, 2);
            repeat (ndig) send_byte(CHAR_0 + 8'($urandom_range(0, 9)));
        end
        case ($urandom_range(0, 5))
            0:       term = CHAR_H;
            1:       term = CHAR_F;
            2, 3:    term = CHAR_TILDE;
            4:       term = ESC_BYTE;
            default: term = 8'($urandom_range(0, 255));
        endcase
        send_byte(term);
    endtask

    // result side: random stalls per item
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // stimulus and final report
    initial
    begin
        logic [7:0] directed[$];
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        burst_mode = 1'b0;
        bytes_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain keys at the byte extremes, each button, prefix mismatch,
        // escape as introducer and as terminator, an unknown terminator
        directed = '{8'h00, 8'hff, "a",
                     ESC_BYTE, "[", CHAR_H,
                     ESC_BYTE, "O", CHAR_F,
                     ESC_BYTE, "[", "5", CHAR_TILDE,
                     ESC_BYTE, "[", "6", CHAR_TILDE,
                     ESC_BYTE, ESC_BYTE, ESC_BYTE, CHAR_H,
                     ESC_BYTE, "[", "7", "Q"};
        foreach (directed[i])
            send_byte(directed[i]);

        // random part: mostly well-formed sequences, some noise bytes
        while (bytes_sent < STIM_BYTES)
        begin
            if ($urandom_range(0, 39) == 0)
                burst_mode = ~burst_mode;
            if ($urandom_range(0, 9) < 7)
                send_sequence();
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        // let the monitor note the last accepted byte before draining
        @(posedge clk);
        while (tracker.pending_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d bytes: %0d key events, %0d button presses",
                 tracker.n_bytes, tracker.n_keys, tracker.n_presses);
        $display("prefix saturated %0d times", tracker.n_saturated);
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #500000;
        $display("timeout with %0d events still pending", tracker.pending_events.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
src/tekd_pkg.sv
src/tekd_parser.sv
src/tekd_out_buf.sv
src/terminal_escape_key_decoder_top.sv
verif/terminal_escape_key_decoder_top_test.sv
